>>> rtl/fcdm_pkg.sv
`default_nettype none

package fcdm_pkg;

  // fraction bits of the sine and cosine values
  localparam int unsigned TRIG_FRAC_BITS = 15;
  localparam int unsigned TRIG_MAG_W     = TRIG_FRAC_BITS + 1;
  localparam int unsigned TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int unsigned PROD_W         = 8 + TRIG_W;
  localparam int unsigned SUM_W          = PROD_W + 1;

  localparam longint unsigned PI_Q30        = 64'd3373259426;
  localparam int unsigned     HALF_TURN_DEG = 180;
  localparam int unsigned     TENTHS_PER_DEG = 10;

  // x / 10 for x below 2^16, x / 360 for x below 4096
  localparam int unsigned DIV10_MUL  = 52429;
  localparam int unsigned DIV10_SH   = 19;
  localparam int unsigned DIV360_MUL = 11651;
  localparam int unsigned DIV360_SH  = 22;

  localparam int unsigned QUAD_DEG = 90;
  localparam int unsigned FULL_DEG = 360;

  typedef enum logic {
    CFG_UPPER_LIMIT = 1'b0,
    CFG_LOWER_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] heading_tenths;
    logic signed [7:0]  stick_forward;
    logic signed [7:0]  stick_strafe;
    logic signed [7:0]  stick_turn;
  } in_t;

  typedef struct packed {
    logic signed [7:0] front_left_drive;
    logic signed [7:0] front_right_drive;
    logic signed [7:0] back_left_drive;
    logic signed [7:0] back_right_drive;
  } out_t;

  typedef logic [TRIG_MAG_W-1:0] trig_mag_t;
  typedef trig_mag_t sin_tab_t [QUAD_DEG+1];

  // shift and subtract quotient, only used while building the table
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // first-quadrant sine, taylor series in q30 then rounded to the output fraction
  function automatic trig_mag_t sin_quadrant(int unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned u;
    longint          sum;
    longint unsigned div;
    int unsigned     sh;
    x    = udiv(longint'(r) * PI_Q30, longint'(HALF_TURN_DEG));
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    sh   = 30 - TRIG_FRAC_BITS;
    for (int unsigned k = 1; k <= 7; k++) begin
      div  = longint'((2 * k) * (2 * k + 1));
      term = (term * x2) >> 30;
      term = udiv(term, div);
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    u = longint'(sum);
    u = (u + (64'd1 << (sh - 1))) >> sh;
    return u[TRIG_MAG_W-1:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int unsigned i = 0; i <= QUAD_DEG; i++) begin
      tab[i] = sin_quadrant(i);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

`default_nettype wire

>>> rtl/field_centric_drive_mixer_unit.sv
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+-------------------------------
// in        | input     | in_valid_i / in_stall_o | in_data_i  (heading, 3 sticks)
// out       | output    | out_valid_o/ out_stall_i| out_data_o (4 wheel drives)
// cfg       | input     | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// eight register stages: divide by 10, divide by 360, fold to 0..359, quadrant,
// sine/cosine table, products, truncating sums, mix and saturate.
// one item per cycle while no stall holds the pipeline; out_valid_o follows the item through every stage.
// reset empties the pipeline and sets the limits to +127 / -127.
// a stall only holds the stages that are full, empty stages keep filling.
`default_nettype none

module field_centric_drive_mixer_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire fcdm_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output fcdm_pkg::out_t       out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [7:0]      cfg_data_i
);

  localparam int unsigned NSTAGE = 8;

  typedef struct packed {
    logic signed [7:0] f;
    logic signed [7:0] s;
    logic signed [7:0] t;
  } stick_t;

  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] en;

  logic [6:0]        upper_q;
  logic signed [7:0] lower_q;

  // per-stage enables, a full stage moves only if the next one moves
  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || !out_stall_i;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[NSTAGE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 7'd127;
      lower_q <= -8'sd127;
    end else if (cfg_valid_i) begin
      unique case (fcdm_pkg::cfg_idx_e'(cfg_index_i))
        fcdm_pkg::CFG_UPPER_LIMIT: upper_q <= cfg_data_i[6:0];
        fcdm_pkg::CFG_LOWER_LIMIT: lower_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // stage 1: whole degrees, magnitude and sign
  logic [15:0] habs;
  logic [31:0] div10_prod;
  logic [11:0] s1_deg_d;
  logic [11:0] s1_deg_q;
  logic        s1_neg_q;
  stick_t      s1_stk_q;

  always_comb begin
    habs       = in_data_i.heading_tenths[15] ? 16'(-in_data_i.heading_tenths)
                                              : 16'(in_data_i.heading_tenths);
    div10_prod = 32'(habs) * 32'(fcdm_pkg::DIV10_MUL);
    s1_deg_d   = 12'(div10_prod >> fcdm_pkg::DIV10_SH);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_deg_q <= s1_deg_d;
      s1_neg_q <= in_data_i.heading_tenths[15];
      s1_stk_q <= '{f: in_data_i.stick_forward, s: in_data_i.stick_strafe,
                    t: in_data_i.stick_turn};
    end
  end

  // stage 2: full turns
  logic [25:0] div360_prod;
  logic [3:0]  s2_turns_d;
  logic [3:0]  s2_turns_q;
  logic [11:0] s2_deg_q;
  logic        s2_neg_q;
  stick_t      s2_stk_q;

  always_comb begin
    div360_prod = 26'(s1_deg_q) * 26'(fcdm_pkg::DIV360_MUL);
    s2_turns_d  = 4'(div360_prod >> fcdm_pkg::DIV360_SH);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_turns_q <= s2_turns_d;
      s2_deg_q   <= s1_deg_q;
      s2_neg_q   <= s1_neg_q;
      s2_stk_q   <= s1_stk_q;
    end
  end

  // stage 3: angle folded into 0..359, negative headings wrap from the top
  logic [11:0] rem_full;
  logic [8:0]  rem;
  logic [8:0]  s3_ang_d;
  logic [8:0]  s3_ang_q;
  stick_t      s3_stk_q;

  always_comb begin
    rem_full = s2_deg_q - 12'(s2_turns_q) * 12'(fcdm_pkg::FULL_DEG);
    rem      = rem_full[8:0];
    s3_ang_d = (s2_neg_q && rem != 9'd0) ? 9'(fcdm_pkg::FULL_DEG) - rem : rem;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_ang_q <= s3_ang_d;
      s3_stk_q <= s2_stk_q;
    end
  end

  // stage 4: quadrant and angle within it
  logic [1:0] s4_quad_d;
  logic [6:0] s4_rem_d;
  logic [1:0] s4_quad_q;
  logic [6:0] s4_rem_q;
  stick_t     s4_stk_q;

  always_comb begin
    priority if (s3_ang_q < 9'(fcdm_pkg::QUAD_DEG)) begin
      s4_quad_d = 2'd0;
      s4_rem_d  = 7'(s3_ang_q);
    end else if (s3_ang_q < 9'(2 * fcdm_pkg::QUAD_DEG)) begin
      s4_quad_d = 2'd1;
      s4_rem_d  = 7'(s3_ang_q - 9'(fcdm_pkg::QUAD_DEG));
    end else if (s3_ang_q < 9'(3 * fcdm_pkg::QUAD_DEG)) begin
      s4_quad_d = 2'd2;
      s4_rem_d  = 7'(s3_ang_q - 9'(2 * fcdm_pkg::QUAD_DEG));
    end else begin
      s4_quad_d = 2'd3;
      s4_rem_d  = 7'(s3_ang_q - 9'(3 * fcdm_pkg::QUAD_DEG));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_quad_q <= s4_quad_d;
      s4_rem_q  <= s4_rem_d;
      s4_stk_q  <= s3_stk_q;
    end
  end

  // stage 5: table lookup, cosine is the sine one quadrant on
  logic [1:0]                           cos_quad;
  logic [6:0]                           sin_idx;
  logic [6:0]                           cos_idx;
  fcdm_pkg::trig_mag_t                  sin_mag;
  fcdm_pkg::trig_mag_t                  cos_mag;
  logic signed [fcdm_pkg::TRIG_W-1:0]   s5_sn_d;
  logic signed [fcdm_pkg::TRIG_W-1:0]   s5_cs_d;
  logic signed [fcdm_pkg::TRIG_W-1:0]   s5_sn_q;
  logic signed [fcdm_pkg::TRIG_W-1:0]   s5_cs_q;
  stick_t                               s5_stk_q;

  always_comb begin
    cos_quad = s4_quad_q + 2'd1;
    sin_idx  = s4_quad_q[0] ? 7'(fcdm_pkg::QUAD_DEG) - s4_rem_q : s4_rem_q;
    cos_idx  = cos_quad[0]  ? 7'(fcdm_pkg::QUAD_DEG) - s4_rem_q : s4_rem_q;
    sin_mag  = fcdm_pkg::SIN_TAB[sin_idx];
    cos_mag  = fcdm_pkg::SIN_TAB[cos_idx];
    s5_sn_d  = s4_quad_q[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    s5_cs_d  = cos_quad[1]  ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_sn_q  <= s5_sn_d;
      s5_cs_q  <= s5_cs_d;
      s5_stk_q <= s4_stk_q;
    end
  end

  // stage 6: rotation products
  logic signed [fcdm_pkg::PROD_W-1:0] s6_fsn_q;
  logic signed [fcdm_pkg::PROD_W-1:0] s6_scs_q;
  logic signed [fcdm_pkg::PROD_W-1:0] s6_fcs_q;
  logic signed [fcdm_pkg::PROD_W-1:0] s6_ssn_q;
  logic signed [7:0]                  s6_t_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_fsn_q <= fcdm_pkg::PROD_W'(s5_stk_q.f) * fcdm_pkg::PROD_W'(s5_sn_q);
      s6_scs_q <= fcdm_pkg::PROD_W'(s5_stk_q.s) * fcdm_pkg::PROD_W'(s5_cs_q);
      s6_fcs_q <= fcdm_pkg::PROD_W'(s5_stk_q.f) * fcdm_pkg::PROD_W'(s5_cs_q);
      s6_ssn_q <= fcdm_pkg::PROD_W'(s5_stk_q.s) * fcdm_pkg::PROD_W'(s5_sn_q);
      s6_t_q   <= s5_stk_q.t;
    end
  end

  // stage 7: exact sums truncated toward zero
  logic signed [fcdm_pkg::SUM_W-1:0] sum_s;
  logic signed [fcdm_pkg::SUM_W-1:0] sum_f;
  logic [fcdm_pkg::SUM_W-1:0]        mag_s;
  logic [fcdm_pkg::SUM_W-1:0]        mag_f;
  logic [9:0]                        shr_s;
  logic [9:0]                        shr_f;
  logic signed [9:0]                 s7_rs_d;
  logic signed [9:0]                 s7_rf_d;
  logic signed [9:0]                 s7_rs_q;
  logic signed [9:0]                 s7_rf_q;
  logic signed [7:0]                 s7_t_q;

  always_comb begin
    sum_s   = fcdm_pkg::SUM_W'(s6_fsn_q) + fcdm_pkg::SUM_W'(s6_scs_q);
    sum_f   = fcdm_pkg::SUM_W'(s6_fcs_q) - fcdm_pkg::SUM_W'(s6_ssn_q);
    mag_s   = sum_s[fcdm_pkg::SUM_W-1] ? -sum_s : sum_s;
    mag_f   = sum_f[fcdm_pkg::SUM_W-1] ? -sum_f : sum_f;
    shr_s   = 10'(mag_s >> fcdm_pkg::TRIG_FRAC_BITS);
    shr_f   = 10'(mag_f >> fcdm_pkg::TRIG_FRAC_BITS);
    s7_rs_d = sum_s[fcdm_pkg::SUM_W-1] ? -$signed(shr_s) : $signed(shr_s);
    s7_rf_d = sum_f[fcdm_pkg::SUM_W-1] ? -$signed(shr_f) : $signed(shr_f);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_rs_q <= s7_rs_d;
      s7_rf_q <= s7_rf_d;
      s7_t_q  <= s6_t_q;
    end
  end

  // stage 8: wheel mix and saturation, upper limit checked first
  logic signed [11:0] rs_x;
  logic signed [11:0] rf_x;
  logic signed [11:0] t_x;
  logic signed [11:0] hi_x;
  logic signed [11:0] lo_x;
  logic signed [11:0] mix_fl;
  logic signed [11:0] mix_fr;
  logic signed [11:0] mix_bl;
  logic signed [11:0] mix_br;
  fcdm_pkg::out_t     out_d;
  fcdm_pkg::out_t     out_q;

  function automatic logic signed [7:0] sat(logic signed [11:0] v,
                                            logic signed [11:0] hi,
                                            logic signed [11:0] lo);
    logic signed [11:0] r;
    priority if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[7:0];
  endfunction

  always_comb begin
    rs_x   = 12'(s7_rs_q);
    rf_x   = 12'(s7_rf_q);
    t_x    = 12'(s7_t_q);
    hi_x   = $signed({5'd0, upper_q});
    lo_x   = 12'(lower_q);
    mix_fl = -rf_x - rs_x - t_x;
    mix_fr =  rf_x - rs_x - t_x;
    mix_bl = -rf_x + rs_x - t_x;
    mix_br =  rf_x + rs_x - t_x;
    out_d.front_left_drive  = sat(mix_fl, hi_x, lo_x);
    out_d.front_right_drive = sat(mix_fr, hi_x, lo_x);
    out_d.back_left_drive   = sat(mix_bl, hi_x, lo_x);
    out_d.back_right_drive  = sat(mix_br, hi_x, lo_x);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
